FILE: sv/cia_pkg.sv
// Shared command and status codes and helpers for the checked integer arithmetic unit.
`timescale 1ns / 1ps

package cia_pkg;

   localparam int DATA_W = 64;

   typedef logic [2:0]        code_type;
   typedef logic [DATA_W-1:0] word_type;

   localparam code_type CMD_ADD  = 3'd0;
   localparam code_type CMD_SUB  = 3'd1;
   localparam code_type CMD_MUL  = 3'd2;
   localparam code_type CMD_DIV  = 3'd3;
   localparam code_type CMD_MOD  = 3'd4;
   localparam code_type CMD_POW  = 3'd5;
   localparam code_type CMD_FACT = 3'd6;

   localparam code_type ST_OK    = 3'd0;
   localparam code_type ST_OVER  = 3'd1;
   localparam code_type ST_UNDER = 3'd2;
   localparam code_type ST_DIVZ  = 3'd3;
   localparam code_type ST_INVAL = 3'd4;

   localparam word_type WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam word_type WORD_ONE = word_type'(1);

   // unsigned magnitude of a two's complement word (MIN maps to 2^63)
   function automatic word_type mag(input word_type v);
      mag = v[DATA_W-1] ? (~v + WORD_ONE) : v;
   endfunction

endpackage

FILE: sv/cia_mul.sv
// Multi-cycle 64x64 unsigned multiplier built on one 32x32 partial product.
`timescale 1ns / 1ps

module cia_mul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cia_pkg::word_type      x,
   input  cia_pkg::word_type      y,
   output logic                   done,
   output logic [2*cia_pkg::DATA_W-1:0] product
);
   import cia_pkg::*;

   localparam int HALF_W = DATA_W / 2;

   logic [2:0]          cnt_ff;
   logic                run_ff;
   logic                done_ff;
   word_type            x_ff;
   word_type            y_ff;
   word_type            pp_ff;
   logic [1:0]          sh_ff;
   logic [2*DATA_W-1:0] acc_ff;

   logic [HALF_W-1:0]   a_half;
   logic [HALF_W-1:0]   b_half;
   word_type            pp_in;
   logic [1:0]          sh_in;
   logic [2*DATA_W-1:0] shifted;

   assign a_half = cnt_ff[0] ? x_ff[DATA_W-1:HALF_W] : x_ff[HALF_W-1:0];
   assign b_half = cnt_ff[1] ? y_ff[DATA_W-1:HALF_W] : y_ff[HALF_W-1:0];
   assign pp_in  = word_type'(a_half) * word_type'(b_half);
   assign sh_in  = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};

   always_comb begin
      unique case (sh_ff)
         2'd0:    shifted = {{DATA_W{1'b0}}, pp_ff};
         2'd1:    shifted = {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
         default: shifted = {pp_ff, {DATA_W{1'b0}}};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 3'd0;
            acc_ff <= '0;
            x_ff   <= x;
            y_ff   <= y;
         end else if (run_ff) begin
            if (cnt_ff != 3'd4) begin
               pp_ff <= pp_in;
               sh_ff <= sh_in;
            end
            // accumulate the partial product taken in the previous cycle
            if (cnt_ff != 3'd0) begin
               acc_ff <= acc_ff + shifted;
            end
            if (cnt_ff == 3'd4) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: sv/cia_div.sv
// Bit-serial restoring divider on unsigned 64-bit magnitudes.
`timescale 1ns / 1ps

module cia_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cia_pkg::word_type dividend,
   input  cia_pkg::word_type divisor,
   output logic              done,
   output cia_pkg::word_type quotient,
   output cia_pkg::word_type remainder
);
   import cia_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;
   word_type         n_ff;
   word_type         r_ff;
   word_type         d_ff;

   logic [DATA_W:0]  trial;
   logic [DATA_W:0]  diff;
   logic             ge;

   assign trial = {r_ff, n_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            n_ff   <= dividend;
            d_ff   <= divisor;
            r_ff   <= '0;
         end else if (run_ff) begin
            r_ff   <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            n_ff   <= {n_ff[DATA_W-2:0], ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = n_ff;
   assign remainder = r_ff;

endmodule

FILE: sv/checked_integer_arith_unit.sv
// Top level: command sequencer for the checked 64-bit integer arithmetic unit.
//
//   channel | ports                                          | direction
//   req     | req_valid, req_stall, req_command, req_operand_a/b | in
//   rsp     | rsp_valid, rsp_stall, rsp_result_value, rsp_status | out
//
// One item at a time. Divide and modulo run in the divider, one quotient bit
// per cycle. Power takes up to 64 multiply steps, factorial up to 21 factors;
// the 32x32 partial product unit sets the multiply step length. Synchronous
// reset clears the sequencer and the result valid. A held result stalls the
// sequencer in its final state only.
`timescale 1ns / 1ps

module checked_integer_arith_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cia_pkg::code_type req_command,
   input  logic signed [cia_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [cia_pkg::DATA_W-1:0] req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [cia_pkg::DATA_W-1:0] rsp_result_value,
   output cia_pkg::code_type rsp_status
);
   import cia_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   code_type   cmd_ff;
   word_type   a_ff, b_ff;
   word_type   cnt_ff, cnt_in;
   logic       neg_ff, neg_in;
   word_type   res_ff, res_in;
   code_type   st_ff, st_in;
   logic       out_valid_ff;
   word_type   out_value_ff;
   code_type   out_status_ff;

   logic       mul_start, mul_done;
   word_type   mul_x, mul_y;
   logic [2*DATA_W-1:0] mul_prod;
   logic       div_start, div_done;
   word_type   div_q, div_r;

   word_type   mag_a, mag_b, neg_b;
   logic [DATA_W:0] sum;
   logic       a_zero, b_zero;
   word_type   prod_lo;
   logic       prod_ok;
   word_type   prod_val;
   word_type   cnt_next;
   logic       out_free;

   cia_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (mul_prod)
   );

   cia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_a),
      .divisor   (mag_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign mag_a   = mag(a_ff);
   assign mag_b   = mag(b_ff);
   assign neg_b   = ~b_ff + WORD_ONE;
   assign a_zero  = (a_ff == '0);
   assign b_zero  = (b_ff == '0);
   assign sum     = {a_ff[DATA_W-1], a_ff}
                  + ((cmd_ff == CMD_SUB) ? {neg_b[DATA_W-1], neg_b}
                                         : {b_ff[DATA_W-1], b_ff});
   assign prod_lo = mul_prod[DATA_W-1:0];
   // fits when the high half is clear and the low half is within the signed limit
   assign prod_ok = (mul_prod[2*DATA_W-1:DATA_W] == '0)
                  && (!prod_lo[DATA_W-1] || (neg_ff && prod_lo[DATA_W-2:0] == '0));
   assign prod_val = neg_ff ? (~prod_lo + WORD_ONE) : prod_lo;
   assign cnt_next = cnt_ff + WORD_ONE;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      mul_start = 1'b0;
      mul_x     = WORD_ONE;
      mul_y     = WORD_ONE;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            res_in   = '0;
            st_in    = ST_OK;
            unique case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  if (cmd_ff == CMD_SUB && b_ff == WORD_MIN) begin
                     st_in = ST_OVER;
                  end else if (sum[DATA_W] != sum[DATA_W-1]) begin
                     st_in = sum[DATA_W] ? ST_UNDER : ST_OVER;
                  end else begin
                     res_in = sum[DATA_W-1:0];
                  end
               end
               CMD_MUL: begin
                  mul_start = 1'b1;
                  mul_x     = mag_a;
                  mul_y     = mag_b;
                  neg_in    = (a_ff[DATA_W-1] != b_ff[DATA_W-1]) && !a_zero && !b_zero;
                  state_in  = S_MUL;
               end
               CMD_DIV, CMD_MOD: begin
                  if (b_zero) begin
                     st_in = ST_DIVZ;
                  end else if (cmd_ff == CMD_DIV && a_ff == WORD_MIN && b_ff == '1) begin
                     st_in = ST_OVER;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               CMD_POW: begin
                  priority if (b_ff[DATA_W-1]) begin
                     st_in = ST_INVAL;
                  end else if (b_zero) begin
                     res_in = WORD_ONE;
                  end else if (a_zero || a_ff == WORD_ONE) begin
                     res_in = a_ff;
                  end else if (a_ff == '1) begin
                     res_in = b_ff[0] ? '1 : WORD_ONE;
                  end else begin
                     mul_start = 1'b1;
                     mul_x     = WORD_ONE;
                     mul_y     = mag_a;
                     neg_in    = a_ff[DATA_W-1];
                     cnt_in    = b_ff;
                     state_in  = S_MUL;
                  end
               end
               CMD_FACT: begin
                  priority if (a_ff[DATA_W-1]) begin
                     st_in = ST_INVAL;
                  end else if (a_zero) begin
                     res_in = WORD_ONE;
                  end else begin
                     mul_start = 1'b1;
                     neg_in    = 1'b0;
                     cnt_in    = WORD_ONE;
                     state_in  = S_MUL;
                  end
               end
               default: begin
                  st_in = ST_INVAL;
               end
            endcase
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_DONE;
               if (!prod_ok) begin
                  res_in = '0;
                  st_in  = neg_ff ? ST_UNDER : ST_OVER;
               end else begin
                  res_in = prod_val;
                  st_in  = ST_OK;
                  if (cmd_ff == CMD_POW && cnt_ff != WORD_ONE) begin
                     // next step: acc * a, both nonzero here
                     cnt_in    = cnt_ff - WORD_ONE;
                     mul_start = 1'b1;
                     mul_x     = mag(prod_val);
                     mul_y     = mag_a;
                     neg_in    = prod_val[DATA_W-1] != a_ff[DATA_W-1];
                     state_in  = S_MUL;
                  end else if (cmd_ff == CMD_FACT && cnt_next <= a_ff) begin
                     cnt_in    = cnt_next;
                     mul_start = 1'b1;
                     mul_x     = prod_val;
                     mul_y     = cnt_next;
                     state_in  = S_MUL;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DONE;
               st_in    = ST_OK;
               if (cmd_ff == CMD_DIV) begin
                  res_in = (a_ff[DATA_W-1] != b_ff[DATA_W-1]) ? (~div_q + WORD_ONE) : div_q;
               end else begin
                  // fold a negative truncated remainder into 0..|b|-1
                  res_in = (a_ff[DATA_W-1] && div_r != '0) ? (mag_b - div_r) : div_r;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_valid) begin
            cmd_ff <= req_command;
            a_ff   <= req_operand_a;
            b_ff   <= req_operand_b;
         end
         cnt_ff <= cnt_in;
         neg_ff <= neg_in;
         res_ff <= res_in;
         st_ff  <= st_in;
         if (state_ff == S_DONE && out_free) begin
            out_valid_ff  <= 1'b1;
            out_value_ff  <= res_ff;
            out_status_ff <= st_ff;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;

endmodule
